// ===== rtl/qte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and helper functions of the quintic trajectory
// evaluator.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int COEFF_COUNT = 6;
  localparam int AXIS_COUNT  = 4;

  localparam int K_W         = $clog2(COEFF_COUNT);
  localparam int CNT_W       = $clog2(COEFF_COUNT + 1);
  localparam int STORE_DEPTH = AXIS_COUNT * COEFF_COUNT;
  localparam int STORE_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int DERIV_COUNT = 4;
  localparam int FAC_W       = 8;
  localparam int RES_W       = 48;
  localparam int SC_W        = RES_W + FAC_W + 1;
  localparam int ACC_W       = SC_W + 3;

  localparam logic [K_W-1:0] K_LAST    = K_W'(COEFF_COUNT - 1);
  localparam logic [1:0]     AXIS_LAST = 2'(AXIS_COUNT - 1);
  localparam logic [1:0]     YAW_AXIS  = 2'd3;

  localparam logic [1:0] CMD_LOAD_COEFF = 2'd0;
  localparam logic [1:0] CMD_LOAD_DUR   = 2'd1;
  localparam logic [1:0] CMD_EVAL       = 2'd2;

  localparam logic signed [RES_W-1:0] ONE_Q16 = 48'sh0000_0001_0000;
  localparam logic signed [RES_W-1:0] MAX48   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] MIN48   = 48'sh8000_0000_0000;

  // Controller to datapath commands.
  typedef struct packed {
    logic           load_coeff;
    logic           load_dur;
    logic           start_eval;
    logic           issue;
    logic           issue_pow;
    logic [K_W-1:0] m;
    logic [K_W-1:0] k;
    logic [1:0]     d;
    logic [1:0]     axis;
    logic           emit;
  } qte_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic busy;
    logic out_free;
  } qte_stat_t;

  // Tag that travels with an operation through the multiplier pipeline.
  typedef struct packed {
    logic             is_pow;
    logic [K_W-1:0]   idx;
    logic [1:0]       d;
    logic [FAC_W-1:0] fac;
  } qte_tag_t;

  // Falling factorial k!/(k-d)! for d up to three.
  function automatic logic [FAC_W-1:0] f_factor(input logic [K_W-1:0] k,
                                                 input logic [1:0] d);
    logic [FAC_W-1:0] f;
    f = FAC_W'(1);
    for (int j = 0; j < 3; j++) begin
      if (j < int'(d)) begin
        f = FAC_W'(f * (FAC_W'(k) - FAC_W'(j)));
      end
    end
    return f;
  endfunction

  // Saturate an accumulator to the 48-bit result range.
  function automatic logic signed [RES_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > ACC_W'(MAX48)) begin
      r = MAX48;
    end else if (v < ACC_W'(MIN48)) begin
      r = MIN48;
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qte_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_in_if
// Input channel: command items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         axis;
  logic [2:0]         coeff_index;
  logic signed [31:0] value;

  modport source (output valid, command, axis, coeff_index, value, input ready);
  modport sink   (input valid, command, axis, coeff_index, value, output ready);
endinterface
`default_nettype wire

// ===== rtl/qte_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_out_if
// Output channel: one per-axis trajectory sample with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis_out;
  logic signed [47:0] position;
  logic signed [47:0] velocity;
  logic signed [47:0] acceleration;
  logic signed [47:0] jerk;
  logic               last;

  modport source (output valid, axis_out, position, velocity, acceleration, jerk, last,
                  input ready);
  modport sink   (input valid, axis_out, position, velocity, acceleration, jerk, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/qte_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_ctrl
// Sequencer: accepts items, steps through the power and product schedule and
// hands finished axes to the output register.
// ----------------------------------------------------------------------------
module qte_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_command_i,
  output logic                   in_ready_o,
  input  wire qte_pkg::qte_stat_t stat_i,
  output qte_pkg::qte_cmd_t      cmd_o
);
  import qte_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POW   = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] m_q, m_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [1:0]       d_q, d_d;
  logic [1:0]       axis_q, axis_d;
  logic [1:0]       d_max;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign d_max      = (k_q >= K_W'(3)) ? 2'd3 : k_q[1:0];

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    k_d     = k_q;
    d_d     = d_q;
    axis_d  = axis_q;
    cmd_o            = '0;
    cmd_o.axis       = axis_q;
    cmd_o.k          = k_q;
    cmd_o.d          = d_q;
    cmd_o.m          = K_W'(k_q - K_W'(d_q));
    cmd_o.load_coeff = accept && (in_command_i == CMD_LOAD_COEFF);
    cmd_o.load_dur   = accept && (in_command_i == CMD_LOAD_DUR);
    cmd_o.start_eval = accept && (in_command_i == CMD_EVAL);
    case (state_q)
      S_IDLE: begin
        if (cmd_o.start_eval) begin
          state_d = S_POW;
          m_d     = CNT_W'(1);
          k_d     = '0;
          d_d     = '0;
          axis_d  = '0;
        end
      end
      S_POW: begin
        if (!stat_i.busy) begin
          if (m_q == CNT_W'(COEFF_COUNT)) begin
            state_d = S_PROD;
          end else begin
            cmd_o.issue     = 1'b1;
            cmd_o.issue_pow = 1'b1;
            cmd_o.m         = m_q[K_W-1:0];
            m_d             = m_q + CNT_W'(1);
          end
        end
      end
      S_PROD: begin
        cmd_o.issue = 1'b1;
        if (d_q == d_max) begin
          d_d = '0;
          k_d = k_q + K_W'(1);
          if (k_q == K_LAST) begin
            k_d     = '0;
            state_d = S_DRAIN;
          end
        end else begin
          d_d = d_q + 2'd1;
        end
      end
      S_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (axis_q == AXIS_LAST) begin
            state_d = S_IDLE;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_PROD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_q     <= '0;
      k_q     <= '0;
      d_q     <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      k_q     <= k_d;
      d_q     <= d_d;
      axis_q  <= axis_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qte_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_dp
// Datapath: coefficient store, power table, pipelined rounding multiplier,
// derivative accumulators and the output register.
// ----------------------------------------------------------------------------
module qte_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qte_pkg::qte_cmd_t  cmd_i,
  output qte_pkg::qte_stat_t      stat_o,
  input  wire logic [1:0]         in_axis_i,
  input  wire logic [2:0]         in_coeff_index_i,
  input  wire logic signed [31:0] in_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              out_axis_o,
  output logic signed [47:0]      out_position_o,
  output logic signed [47:0]      out_velocity_o,
  output logic signed [47:0]      out_acceleration_o,
  output logic signed [47:0]      out_jerk_o,
  output logic                    out_last_o
);
  import qte_pkg::*;

  logic signed [31:0]      store_q [STORE_DEPTH];
  logic signed [31:0]      dur_q;
  logic signed [31:0]      t_q;
  logic signed [RES_W-1:0] pw_q [COEFF_COUNT];
  logic signed [ACC_W-1:0] acc_q [DERIV_COUNT];

  logic [STORE_W-1:0]      wr_idx, rd_idx;
  logic                    wr_ok;
  logic signed [RES_W-1:0] op_a;
  logic signed [31:0]      op_b;
  qte_tag_t                tag_in;

  logic                    v1_q, v2_q, v3_q, v4_q;
  qte_tag_t                tag1_q, tag2_q, tag3_q;
  logic [1:0]              d4_q;
  logic                    neg1_q, neg2_q;
  logic [RES_W-1:0]        ua1_q;
  logic [31:0]             ub1_q;
  logic [63:0]             lo2_q;
  logic [RES_W-1:0]        mid2_q;
  logic signed [RES_W-1:0] prod3_q;
  logic signed [SC_W-1:0]  sc4_q;

  logic [64:0]             rnd;
  logic [64:0]             mag;
  logic signed [RES_W-1:0] fmul_res;
  logic                    out_valid_q;

  // Store addressing.
  assign wr_ok  = (int'(in_axis_i) < AXIS_COUNT) && (int'(in_coeff_index_i) < COEFF_COUNT);
  assign wr_idx = STORE_W'(int'(in_axis_i) * COEFF_COUNT + int'(in_coeff_index_i));
  assign rd_idx = STORE_W'(int'(cmd_i.axis) * COEFF_COUNT + int'(cmd_i.k));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
      dur_q <= '0;
    end else begin
      if (cmd_i.load_coeff && wr_ok) begin
        store_q[wr_idx] <= in_value_i;
      end
      if (cmd_i.load_dur) begin
        dur_q <= in_value_i;
      end
    end
  end

  // Operand selection: a power step multiplies the previous power by t, a
  // product step multiplies a power by a stored coefficient.
  always_comb begin
    if (cmd_i.issue_pow) begin
      op_a = pw_q[K_W'(cmd_i.m - K_W'(1))];
      op_b = t_q;
    end else begin
      op_a = pw_q[cmd_i.m];
      op_b = store_q[rd_idx];
    end
    tag_in.is_pow = cmd_i.issue_pow;
    tag_in.idx    = cmd_i.m;
    tag_in.d      = cmd_i.d;
    tag_in.fac    = f_factor(cmd_i.k, cmd_i.d);
  end

  // Stage three: round half away from zero and saturate.
  always_comb begin
    rnd = {1'b0, lo2_q} + 65'h8000;
    mag = {1'b0, mid2_q, 16'b0} + 65'(rnd[64:16]);
    if (mid2_q >= 48'h8000_0000_0000) begin
      fmul_res = neg2_q ? MIN48 : MAX48;
    end else if (neg2_q) begin
      fmul_res = (mag > 65'h8000_0000_0000) ? MIN48 : (48'sd0 - $signed(mag[RES_W-1:0]));
    end else begin
      fmul_res = (mag > 65'h7FFF_FFFF_FFFF) ? MAX48 : $signed(mag[RES_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q && !tag2_q.is_pow;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_eval) begin
      t_q      <= (in_value_i < dur_q) ? in_value_i : dur_q;
      pw_q[0]  <= ONE_Q16;
    end
    // Stage one: magnitudes and sign.
    tag1_q <= tag_in;
    neg1_q <= op_a[RES_W-1] ^ op_b[31];
    ua1_q  <= op_a[RES_W-1] ? (48'd0 - op_a) : op_a;
    ub1_q  <= op_b[31] ? (32'd0 - op_b) : op_b;
    // Stage two: split partial products.
    tag2_q <= tag1_q;
    neg2_q <= neg1_q;
    lo2_q  <= 64'(ua1_q[31:0]) * 64'(ub1_q);
    mid2_q <= RES_W'(ua1_q[RES_W-1:32]) * RES_W'(ub1_q);
    // Stage three: rounded product, or a new power of t.
    tag3_q  <= tag2_q;
    prod3_q <= fmul_res;
    if (v2_q && tag2_q.is_pow) begin
      pw_q[tag2_q.idx] <= fmul_res;
    end
    // Stage four: scale by the falling factorial.
    d4_q  <= tag3_q.d;
    sc4_q <= SC_W'(prod3_q) * SC_W'($signed({1'b0, tag3_q.fac}));
    // Stage five: accumulate per derivative order.
    if (cmd_i.start_eval || cmd_i.emit) begin
      for (int i = 0; i < DERIV_COUNT; i++) begin
        acc_q[i] <= '0;
      end
    end else if (v4_q) begin
      acc_q[d4_q] <= acc_q[d4_q] + ACC_W'(sc4_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_axis_o     <= cmd_i.axis;
      out_position_o <= sat48(acc_q[0]);
      out_velocity_o <= sat48(acc_q[1]);
      if (cmd_i.axis == YAW_AXIS) begin
        out_acceleration_o <= '0;
        out_jerk_o         <= '0;
      end else begin
        out_acceleration_o <= sat48(acc_q[2]);
        out_jerk_o         <= sat48(acc_q[3]);
      end
      out_last_o <= (cmd_i.axis == AXIS_LAST);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.busy     = v1_q || v2_q || v3_q || v4_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !stat_o.busy)
    else $error("results captured while products still in flight");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> stat_o.out_free)
    else $error("output register overwritten before transfer");

  a_pow_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && cmd_i.issue_pow) |-> !stat_o.busy)
    else $error("power step issued before previous power was written");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("captured result not presented");

endmodule
`default_nettype wire

// ===== rtl/quintic_trajectory_evaluator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_unit
// Four-axis quintic trajectory store and evaluator with value, rate,
// acceleration and jerk outputs per axis (yaw reports zero for the last two).
// ----------------------------------------------------------------------------
// Load items (coefficient or duration) leave the input open and cause no transfer.
// An evaluate item closes the input through the power steps and then, for each
// axis, its products, drain and output hand-off. A result still waiting when
// the next one is ready holds the evaluation until it is transferred.
// Reset (asynchronous, active low) clears the coefficient store and duration.
// ----------------------------------------------------------------------------
module quintic_trajectory_evaluator_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qte_in_if.sink     in_i,
  qte_out_if.source  out_o
);
  import qte_pkg::*;

  // The controller walks the evaluation schedule: first the powers of the
  // clamped time, each depending on the one before, so each waits for the
  // multiplier pipeline to empty. Then, per axis, one product per cycle of a
  // power with a coefficient, each routed to the accumulator of its
  // derivative order and scaled by the matching falling factorial.
  qte_cmd_t  cmd;
  qte_stat_t stat;

  qte_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // The datapath keeps the output register apart from the accumulators, so
  // the next axis is computed while the previous result waits for its
  // transfer, and a new item is taken while the final result still waits.
  qte_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_axis_i          (in_i.axis),
    .in_coeff_index_i   (in_i.coeff_index),
    .in_value_i         (in_i.value),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_axis_o         (out_o.axis_out),
    .out_position_o     (out_o.position),
    .out_velocity_o     (out_o.velocity),
    .out_acceleration_o (out_o.acceleration),
    .out_jerk_o         (out_o.jerk),
    .out_last_o         (out_o.last)
  );

endmodule
`default_nettype wire

// ===== verif/quintic_trajectory_evaluator_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_unit_tb
// Self-checking bench for the four-axis quintic trajectory evaluator. A
// queue-fed driver pushes coefficient loads, duration loads, evaluate and
// unused commands into the block. A bit-exact predictor keeps its own copy
// of the trajectory store and queues the four per-axis samples that each
// evaluate must produce. A monitor takes every output transfer and compares
// it field by field with the oldest queued sample.
// ----------------------------------------------------------------------------
module quintic_trajectory_evaluator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names commands 0 to 2 only; command 3 must be dropped silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_CMDS  = 85;
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES  = 600;

  // One command as it travels over the input channel.
  typedef struct {
    logic [1:0]         command;
    logic [1:0]         axis;
    logic [2:0]         coeff_index;
    logic signed [31:0] value;
  } traj_cmd_t;

  // One per-axis trajectory sample as the output channel carries it.
  typedef struct {
    logic [1:0]         axis;
    logic signed [47:0] position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic signed [47:0] jerk;
    logic               last;
  } axis_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  qte_in_if  cmd_if ();
  qte_out_if sample_if ();

  quintic_trajectory_evaluator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (sample_if)
  );

  always #1 clk_i = ~clk_i;

  // Commands still to be offered, and samples the block still owes us.
  traj_cmd_t    pending_cmds[$];
  axis_sample_t expected_samples[$];

  // Private copy of the trajectory store, updated at each accepted transfer.
  logic signed [31:0] coeff_model [qte_pkg::AXIS_COUNT][qte_pkg::COEFF_COUNT];
  logic signed [31:0] duration_model;

  int        total_cmds;
  int        accepted_cmds;
  int        mismatch_count;
  int        cycle_count;
  int        hold_left;
  bit        hold_done;
  traj_cmd_t head_cmd;

  // --------------------------------------------------------------------------
  // Trajectory predictor
  // --------------------------------------------------------------------------

  // Q32.16 times Q16.16: exact product, rounded half away from zero on the
  // 16 dropped bits, then saturated to the 48-bit result range. The work is
  // done on magnitudes so that rounding is symmetric about zero.
  function automatic logic signed [47:0] q16_mul(input logic signed [47:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [47:0] mag_a;
    logic [31:0] mag_b;
    logic [79:0] prod;
    logic [63:0] mag;
    neg   = a[47] ^ b[31];
    mag_a = a[47] ? 48'(-a) : 48'(a);
    mag_b = b[31] ? 32'(-b) : 32'(b);
    prod  = 80'(mag_a) * 80'(mag_b) + 80'h8000;
    mag   = prod[79:16];
    if (neg) begin
      if (mag > 64'h0000_8000_0000_0000) begin
        return qte_pkg::MIN48;
      end
      return 48'(-mag);
    end
    if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
      return qte_pkg::MAX48;
    end
    return mag[47:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input longint v);
    if (v > longint'(qte_pkg::MAX48)) begin
      return qte_pkg::MAX48;
    end
    if (v < longint'(qte_pkg::MIN48)) begin
      return qte_pkg::MIN48;
    end
    return v[47:0];
  endfunction

  // Queue the four samples of an evaluate at the given elapsed time. The time
  // is clamped from above only, so negative times pass through unchanged and
  // a negative duration pins every time above it to the duration itself.
  task automatic predict_samples(input logic signed [31:0] elapsed);
    logic signed [31:0] t;
    logic signed [47:0] powers [qte_pkg::COEFF_COUNT];
    logic signed [47:0] deriv [4];
    longint             acc;
    longint             fac;
    axis_sample_t       s;
    t = (elapsed < duration_model) ? elapsed : duration_model;
    powers[0] = qte_pkg::ONE_Q16;
    for (int k = 1; k < qte_pkg::COEFF_COUNT; k++) begin
      powers[k] = q16_mul(powers[k-1], t);
    end
    for (int a = 0; a < qte_pkg::AXIS_COUNT; a++) begin
      for (int d = 0; d < 4; d++) begin
        // Derivative d of c_k * t^k is k!/(k-d)! * c_k * t^(k-d); the terms
        // are summed at full width and saturated once.
        acc = 0;
        for (int k = d; k < qte_pkg::COEFF_COUNT; k++) begin
          fac = 1;
          for (int j = 0; j < d; j++) begin
            fac = fac * (k - j);
          end
          acc += fac * longint'(q16_mul(powers[k-d], coeff_model[a][k]));
        end
        deriv[d] = clamp48(acc);
      end
      s.axis         = 2'(a);
      s.position     = deriv[0];
      s.velocity     = deriv[1];
      // Yaw only carries angle and rate.
      s.acceleration = (2'(a) == qte_pkg::YAW_AXIS) ? '0 : deriv[2];
      s.jerk         = (2'(a) == qte_pkg::YAW_AXIS) ? '0 : deriv[3];
      s.last         = (a == qte_pkg::AXIS_COUNT - 1);
      expected_samples.push_back(s);
    end
  endtask

  // Update the store copy for one accepted command; evaluates queue samples.
  task automatic apply_command(input logic [1:0] command, input logic [1:0] axis,
                               input logic [2:0] coeff_index,
                               input logic signed [31:0] value);
    case (command)
      qte_pkg::CMD_LOAD_COEFF: begin
        // Loads aimed past the store are dropped without effect.
        if (int'(axis) < qte_pkg::AXIS_COUNT && int'(coeff_index) < qte_pkg::COEFF_COUNT) begin
          coeff_model[axis][coeff_index] = value;
        end
      end
      qte_pkg::CMD_LOAD_DUR: begin
        duration_model = value;
      end
      qte_pkg::CMD_EVAL: begin
        predict_samples(value);
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_cmd(input logic [1:0] command, input logic [1:0] axis,
                           input logic [2:0] coeff_index, input logic signed [31:0] value);
    traj_cmd_t c;
    c.command     = command;
    c.axis        = axis;
    c.coeff_index = coeff_index;
    c.value       = value;
    pending_cmds.push_back(c);
  endtask

  // Mostly a value in [-span, span] so that trajectories stay in a useful
  // range, now and then a corner value or a fully random word so that every
  // bit of the value field toggles.
  function automatic logic signed [31:0] pick_value(input logic [31:0] span);
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0001_0000;
          4:       v = 32'hFFFF_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = $urandom_range(0, 2 * span);
        v = v - span;
      end
    endcase
    return v;
  endfunction

  // Idle schedule: the sender rarely idles while the receiver mostly stalls
  // in the first third of the run, the reverse in the second, and neither
  // idles in the last third.
  function automatic int idle_phase();
    if (accepted_cmds * 3 < total_cmds) begin
      return 0;
    end
    if (accepted_cmds * 3 < total_cmds * 2) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic bit sender_pauses();
    case (idle_phase())
      0:       return $urandom_range(0, 99) < 11;
      1:       return $urandom_range(0, 99) < 88;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_ready();
    if (hold_left != 0) begin
      return 1'b0;
    end
    case (idle_phase())
      0:       return $urandom_range(0, 99) >= 88;
      1:       return $urandom_range(0, 99) >= 11;
      default: return 1'b1;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_sample();
    axis_sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("sample with no expectation waiting", 48'(sample_if.axis_out), '0);
      return;
    end
    want = expected_samples.pop_front();
    if (sample_if.axis_out !== want.axis) begin
      report_mismatch("axis_out", 48'(sample_if.axis_out), 48'(want.axis));
    end
    if (sample_if.position !== want.position) begin
      report_mismatch("position", sample_if.position, want.position);
    end
    if (sample_if.velocity !== want.velocity) begin
      report_mismatch("velocity", sample_if.velocity, want.velocity);
    end
    if (sample_if.acceleration !== want.acceleration) begin
      report_mismatch("acceleration", sample_if.acceleration, want.acceleration);
    end
    if (sample_if.jerk !== want.jerk) begin
      report_mismatch("jerk", sample_if.jerk, want.jerk);
    end
    if (sample_if.last !== want.last) begin
      report_mismatch("last", 48'(sample_if.last), 48'(want.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: a transfer happens at an edge where valid and ready are both high.
  // The predictor is updated at that edge from the payload still on the bus,
  // then the next command is put up, or valid drops while the sender idles. Valid
  // is never lowered while a command waits for its transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(cmd_if.command, cmd_if.axis, cmd_if.coeff_index, cmd_if.value);
        accepted_cmds <= accepted_cmds + 1;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && !sender_pauses()) begin
          head_cmd = pending_cmds.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.command     <= head_cmd.command;
          cmd_if.axis        <= head_cmd.axis;
          cmd_if.coeff_index <= head_cmd.coeff_index;
          cmd_if.value       <= head_cmd.value;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer, then choose ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready) begin
        check_sample();
      end
      sample_if.ready <= receiver_ready();
    end
  end

  // Back-pressure: once, late in the run where the sender never idles, the
  // receiver holds off for a long stretch. An evaluate then cannot drain, so
  // the block has to close its input while commands keep being offered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cmds * 6 >= total_cmds * 5) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    int        counted;
    int        pick;
    traj_cmd_t c;

    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = '0;
    cmd_if.axis        = '0;
    cmd_if.coeff_index = '0;
    cmd_if.value       = '0;
    sample_if.ready    = 1'b0;
    accepted_cmds      = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
    hold_left          = 0;
    hold_done          = 1'b0;

    // The block clears its store at reset; so does the predictor.
    for (int a = 0; a < qte_pkg::AXIS_COUNT; a++) begin
      for (int k = 0; k < qte_pkg::COEFF_COUNT; k++) begin
        coeff_model[a][k] = '0;
      end
    end
    duration_model = '0;

    // Directed part. An evaluate straight after reset must give all zeros.
    queue_cmd(qte_pkg::CMD_EVAL, 2'd0, 3'd0, 32'h0001_0000);
    // Largest duration, so that the next evaluates are not clamped.
    queue_cmd(qte_pkg::CMD_LOAD_DUR, 2'd3, 3'd7, 32'h7FFF_FFFF);
    // Every power on x, four of them at the extremes of the value field.
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd1, 32'h8000_0000);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd2, 32'h7FFF_FFFF);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd3, 32'h8000_0000);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd4, 32'h0001_0000);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd0, 3'd5, 32'hFFFF_FFFF);
    // The other axes; yaw gets a second-order term that must not show up in its acceleration.
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd1, 3'd5, 32'h8000_0000);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd2, 3'd3, 32'h0000_0001);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd3, 3'd1, 32'h7FFF_FFFF);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd3, 3'd2, 32'h0001_0000);
    // Largest and most negative times drive sums into saturation; a time of one half follows.
    queue_cmd(qte_pkg::CMD_EVAL, 2'd0, 3'd0, 32'h7FFF_FFFF);
    queue_cmd(qte_pkg::CMD_EVAL, 2'd0, 3'd0, 32'h8000_0000);
    queue_cmd(qte_pkg::CMD_EVAL, 2'd0, 3'd0, 32'h0000_8000);
    // Loads past the store and the unused command must change nothing.
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd3, 3'd6, 32'h1234_5678);
    queue_cmd(qte_pkg::CMD_LOAD_COEFF, 2'd3, 3'd7, 32'hFFFF_FFFF);
    queue_cmd(CMD_UNUSED, 2'd3, 3'd7, 32'hFFFF_FFFF);
    // A negative duration clamps a positive time down to itself.
    queue_cmd(qte_pkg::CMD_LOAD_DUR, 2'd0, 3'd0, 32'hFFFE_8000);
    queue_cmd(qte_pkg::CMD_EVAL, 2'd3, 3'd7, 32'h0002_0000);
    // Zero duration: any later time collapses to t = 0.
    queue_cmd(qte_pkg::CMD_LOAD_DUR, 2'd0, 3'd0, 32'h0000_0000);
    queue_cmd(qte_pkg::CMD_EVAL, 2'd1, 3'd5, 32'h7FFF_FFFF);

    // Random part: mostly sensible trajectories (modest coefficients, a few
    // seconds of duration and time), with corner values mixed in. Commands
    // that the block drops do not count toward RANDOM_CMDS.
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      pick          = $urandom_range(0, 99);
      c.axis        = 2'($urandom_range(0, 3));
      c.coeff_index = 3'($urandom_range(0, 7));
      if (pick < 45) begin
        c.command = qte_pkg::CMD_LOAD_COEFF;
        if ($urandom_range(0, 9) != 0) begin
          c.coeff_index = 3'($urandom_range(0, qte_pkg::COEFF_COUNT - 1));
        end
        c.value = pick_value(32'h0040_0000);
        if (int'(c.coeff_index) < qte_pkg::COEFF_COUNT) begin
          counted++;
        end
      end else if (pick < 55) begin
        c.command = qte_pkg::CMD_LOAD_DUR;
        c.value   = pick_value(32'h0004_0000);
        counted++;
      end else if (pick < 95) begin
        c.command = qte_pkg::CMD_EVAL;
        c.value   = pick_value(32'h0005_0000);
        counted++;
      end else begin
        c.command = CMD_UNUSED;
        c.value   = $urandom;
      end
      pending_cmds.push_back(c);
    end
    total_cmds = pending_cmds.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled mid-cycle so that the driver's and monitor's edge updates are
    // all settled.
    do begin
      @(negedge clk_i);
    end while (pending_cmds.size() != 0 || cmd_if.valid || expected_samples.size() != 0);

    // Keep the clock running for DRAIN_CYCLES to catch any stray sample.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/qte_pkg.sv
rtl/qte_in_if.sv
rtl/qte_out_if.sv
rtl/qte_ctrl.sv
rtl/qte_dp.sv
rtl/quintic_trajectory_evaluator_unit.sv
verif/quintic_trajectory_evaluator_unit_tb.sv
